// ===== design/mcwd_pkg.sv =====
// Shared types and constants of the earliest-finish worker dispatcher.
// Used by the controller, the datapath and the top level; depends on nothing.
package mcwd_pkg;

   // Worker pool
   localparam int NUM_WORKERS   = 3;
   localparam int WORKER_SLOTS  = 4;
   localparam int WORKER_W      = 2;
   localparam int ACTIVE        = (NUM_WORKERS > WORKER_SLOTS) ? WORKER_SLOTS : NUM_WORKERS;

   // Time and cost widths
   localparam int TIME_W        = 24;
   localparam int SERVICE_W     = 8;
   localparam int SLOW_W        = 4;
   localparam int NEED_W        = SERVICE_W + SLOW_W;
   localparam int COST_W        = TIME_W + 1;
   localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};
   localparam logic [TIME_W-1:0] COST_SENTINEL = TIME_W'(9999);

   // Register port
   localparam int CSR_INDEX_W   = 8;

   typedef struct packed {
      logic [SERVICE_W-1:0] service_time;
      logic [TIME_W-1:0]    arrival_time;
   } req_type;

   typedef struct packed {
      logic [WORKER_W-1:0] chosen_worker;
      logic [TIME_W-1:0]   start_time;
      logic [TIME_W-1:0]   finish_time;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                load;
      logic                eval;
      logic                first;
      logic                commit;
      logic [WORKER_W-1:0] idx;
   } ctl_cmd_type;

endpackage

// ===== design/mcwd_ctrl.sv =====
// Sequencer of the dispatcher: accepts an item, steps the cost unit over
// the active workers, then commits into the result register. Uses mcwd_pkg.
module mcwd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mcwd_pkg::ctl_cmd_type cmd
);
   import mcwd_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_COMMIT} state_type;

   localparam logic [WORKER_W-1:0] LAST_IDX = WORKER_W'(ACTIVE - 1);

   state_type           state_ff, state_in;
   logic [WORKER_W-1:0] idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                do_commit;

   // Commit only when the result register is free or draining
   assign do_commit = (state_ff == ST_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
               idx_in   = '0;
            end
         end
         ST_EVAL: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_COMMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            if (do_commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;

   assign cmd.load   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.eval   = (state_ff == ST_EVAL);
   assign cmd.first  = (idx_ff == '0);
   assign cmd.commit = do_commit;
   assign cmd.idx    = idx_ff;

endmodule

// ===== design/mcwd_dp.sv =====
// Datapath of the dispatcher: slowness registers, busy-until times, the
// shared cost unit, the running minimum and the result register. Uses mcwd_pkg.
module mcwd_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  mcwd_pkg::ctl_cmd_type        cmd,
   input  mcwd_pkg::req_type            req_data,
   input  logic                         csr_write,
   input  logic [mcwd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mcwd_pkg::SLOW_W-1:0]  csr_data,
   output mcwd_pkg::rsp_type            rsp_data
);
   import mcwd_pkg::*;

   logic [SLOW_W-1:0]    slow_ff  [WORKER_SLOTS];
   logic [TIME_W-1:0]    busy_ff  [WORKER_SLOTS];
   logic [SERVICE_W-1:0] service_ff;
   logic [TIME_W-1:0]    arrival_ff;
   logic [COST_W-1:0]    best_ff, best_in;
   logic [WORKER_W-1:0]  pick_ff, pick_in;
   logic [TIME_W-1:0]    start_ff, start_in;
   logic [NEED_W-1:0]    need_ff, need_in;
   rsp_type              rsp_ff;

   logic [SLOW_W-1:0]    slow_sel;
   logic [TIME_W-1:0]    busy_sel;
   logic [NEED_W-1:0]    need;
   logic [TIME_W-1:0]    wait_t;
   logic [COST_W-1:0]    cost;
   logic [COST_W-1:0]    finish_sum;
   logic [TIME_W-1:0]    finish;

   // Cost of the worker under evaluation
   assign slow_sel = slow_ff[cmd.idx];
   assign busy_sel = busy_ff[cmd.idx];
   assign need     = NEED_W'(service_ff) * NEED_W'(slow_sel);
   assign wait_t   = (busy_sel > arrival_ff) ? (busy_sel - arrival_ff) : '0;
   assign cost     = COST_W'(wait_t) + COST_W'(need);

   // Running minimum; worker 0 is the default pick
   always_comb begin
      best_in  = best_ff;
      pick_in  = pick_ff;
      start_in = start_ff;
      need_in  = need_ff;
      if (cmd.eval) begin
         if (cmd.first) begin
            best_in  = (cost < COST_W'(COST_SENTINEL)) ? cost : COST_W'(COST_SENTINEL);
            pick_in  = cmd.idx;
            start_in = busy_sel;
            need_in  = need;
         end else if (cost < best_ff) begin
            best_in  = cost;
            pick_in  = cmd.idx;
            start_in = busy_sel;
            need_in  = need;
         end
      end
   end

   // New busy-until, saturating
   assign finish_sum = COST_W'(start_ff) + COST_W'(need_ff);
   assign finish     = (finish_sum > COST_W'(TIME_MAX)) ? TIME_MAX : finish_sum[TIME_W-1:0];

   // Item and scan registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         service_ff <= req_data.service_time;
         arrival_ff <= req_data.arrival_time;
      end
      best_ff  <= best_in;
      pick_ff  <= pick_in;
      start_ff <= start_in;
      need_ff  <= need_in;
      if (cmd.commit) begin
         rsp_ff.chosen_worker <= pick_ff;
         rsp_ff.start_time    <= start_ff;
         rsp_ff.finish_time   <= finish;
      end
   end

   // Per-worker state: slowness registers and busy-until times
   for (genvar w = 0; w < WORKER_SLOTS; w++) begin : g_worker
      always_ff @(posedge clock) begin
         if (reset) begin
            slow_ff[w] <= SLOW_W'(w + 1);
            busy_ff[w] <= '0;
         end else begin
            if (csr_write && (csr_index == CSR_INDEX_W'(w))) begin
               slow_ff[w] <= csr_data;
            end
            if (cmd.commit && (pick_ff == WORKER_W'(w))) begin
               busy_ff[w] <= finish;
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/min_completion_worker_dispatch.sv =====
// Top level of the earliest-finish worker dispatcher.
// Instantiates mcwd_ctrl and mcwd_dp; uses mcwd_pkg.
//
//  channel  ports                        direction  moves
//  req      req_valid/req_stall/req_data  in         job: service and arrival time
//  rsp      rsp_valid/rsp_stall/rsp_data  out        worker, start and finish time
//  csr      csr_valid/csr_ready/index/data in        slowness of worker 0..3
//
// An item is accepted, then stepped over each active worker in turn
// through the single shared cost unit, then the chosen worker is committed.
// Reset clears all busy-until times and sets the slowness of worker i to i + 1.
// The result register holds while rsp_stall is high; the next item is accepted
// meanwhile, and its commit waits until that register drains.
// Register writes are always taken; indexes beyond worker 3 are ignored.
module min_completion_worker_dispatch (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mcwd_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mcwd_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mcwd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mcwd_pkg::SLOW_W-1:0]       csr_data
);
   import mcwd_pkg::*;

   ctl_cmd_type cmd;
   logic        csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Sequencer
   mcwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath
   mcwd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule
